// ===== sv/nlm_pkg.sv =====
package nlm_pkg;
	localparam int MAX_IMAGE_SIDE  = 32;
	localparam int MAX_PATCH_SIDE  = 8;
	localparam int MAX_SEARCH_SIDE = 8;
	localparam logic [31:0] FAR_DISTANCE = 32'h0014_0000;

	localparam logic [2:0] REG_IMAGE_ROWS  = 3'd0;
	localparam logic [2:0] REG_IMAGE_COLS  = 3'd1;
	localparam logic [2:0] REG_PATCH_ROWS  = 3'd2;
	localparam logic [2:0] REG_PATCH_COLS  = 3'd3;
	localparam logic [2:0] REG_SEARCH_ROWS = 3'd4;
	localparam logic [2:0] REG_SEARCH_COLS = 3'd5;
	localparam logic [2:0] REG_SKIP_STEP   = 3'd6;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	typedef struct packed {
		logic       start;     // latch request and reset counters
		logic       cand_init; // set up candidate at current offsets
		logic       acc_step;  // accumulate one element
		logic       div_start; // start divider
		logic       div_step;  // one quotient bit
		logic       emit;      // load output register
		logic       adv;       // advance offsets
	} nlm_cmd_t;

	typedef struct packed {
		logic ref_ok;
		logic far;
		logic elem_last;
		logic div_done;
		logic win_last;
	} nlm_sts_t;

	function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] hi);
		if (v == 6'd0) return 6'd1;
		if (v > hi) return hi;
		return v;
	endfunction
endpackage

// ===== sv/nlm_ctrl.sv =====
module nlm_ctrl import nlm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req,
	input  nlm_sts_t sts,
	input  logic     out_free,
	output nlm_cmd_t cmd,
	output logic     busy
);
	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_CAND, S_ACC, S_DIV, S_EMIT} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.start = (state_q == S_IDLE) && req;
		unique case (state_q)
			S_IDLE: ;
			S_CHECK: cmd.cand_init = sts.ref_ok;
			S_CAND: begin
				if (!sts.far) cmd.acc_step = 1'b1;
			end
			S_ACC: begin
				cmd.acc_step = !sts.elem_last;
				cmd.div_start = sts.elem_last;
			end
			S_DIV: cmd.div_step = !sts.div_done;
			S_EMIT: begin
				cmd.emit = out_free;
				cmd.adv = out_free && !sts.win_last;
				cmd.cand_init = out_free && !sts.win_last;
			end
			default: ;
		endcase
	end

	// Candidate setup happens on entry to S_CAND; the first element is read there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req) state_q <= S_CHECK;
				S_CHECK: state_q <= sts.ref_ok ? S_CAND : S_IDLE;
				S_CAND: state_q <= sts.far ? S_EMIT : S_ACC;
				S_ACC: if (sts.elem_last) state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_EMIT;
				S_EMIT: if (out_free) state_q <= sts.win_last ? S_IDLE : S_CAND;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ===== sv/nlm_datapath.sv =====
module nlm_datapath import nlm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  nlm_cmd_t    cmd,
	output nlm_sts_t    sts,
	input  logic        wr_en,
	input  logic [15:0] wr_addr,
	input  logic [15:0] wr_data,
	input  logic [4:0]  grid_col,
	input  logic [4:0]  grid_row,
	input  logic [5:0]  image_rows,
	input  logic [5:0]  image_cols,
	input  logic [3:0]  patch_rows,
	input  logic [3:0]  patch_cols,
	input  logic [3:0]  search_rows,
	input  logic [3:0]  search_cols,
	input  logic [5:0]  skip_step,
	output logic [31:0] res_distance,
	output logic [5:0]  res_index,
	output logic        res_far,
	output logic        res_last
);
	logic [15:0] mem [65536];
	logic [15:0] rd_a, rd_b;

	logic [5:0] ir, ic, sk;
	logic [3:0] pr, pc, sr, sc;
	logic [6:0] len;
	logic signed [7:0] gr, gc;
	logic [10:0] r0_q, c0_q;
	logic [9:0] refp_q, candp_c;
	logic [3:0] ii_q, jj_q;
	logic [5:0] e_q;
	logic signed [8:0] cr, cc;
	logic far_c;
	logic [37:0] sum_q;
	logic [37:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0]  dcnt_q;
	logic        qsat_q;
	logic        rd_vld_q;

	always_comb begin
		ir = clamp6(image_rows, 6'(MAX_IMAGE_SIDE));
		ic = clamp6(image_cols, 6'(MAX_IMAGE_SIDE));
		pr = 4'(clamp6({2'b0, patch_rows}, 6'(MAX_PATCH_SIDE)));
		pc = 4'(clamp6({2'b0, patch_cols}, 6'(MAX_PATCH_SIDE)));
		sr = 4'(clamp6({2'b0, search_rows}, 6'(MAX_SEARCH_SIDE)));
		sc = 4'(clamp6({2'b0, search_cols}, 6'(MAX_SEARCH_SIDE)));
		sk = clamp6(skip_step, 6'd32);
		gr = $signed({2'b0, ir}) - $signed({4'b0, pr}) + 8'sd1;
		gc = $signed({2'b0, ic}) - $signed({4'b0, pc}) + 8'sd1;
		len = 7'(pr * pc);
		cr = $signed({1'b0, 8'(r0_q)}) - $signed({6'b0, sr[3:1]}) + $signed({5'b0, jj_q});
		cc = $signed({1'b0, 8'(c0_q)}) - $signed({6'b0, sc[3:1]}) + $signed({5'b0, ii_q});
		far_c = cr < 0 || cr >= 9'(gr) || cc < 0 || cc >= 9'(gc);
		candp_c = 10'($unsigned(cc)) * 10'($unsigned(gr)) + 10'($unsigned(cr));
	end

	assign sts.ref_ok = gr > 0 && gc > 0 && r0_q < 11'($unsigned(gr)) && c0_q < 11'($unsigned(gc));
	assign sts.far = far_c;
	assign sts.elem_last = rd_vld_q && (e_q == len[5:0] + 6'd0) ;
	assign sts.div_done = (dcnt_q == 6'd0);
	assign sts.win_last = (ii_q == sc - 4'd1) && (jj_q == sr - 4'd1);

	// Store: one write port for loads, one read stream for the reference and candidate.
	logic read_go;
	logic [5:0] rd_e;
	assign read_go = cmd.acc_step;
	assign rd_e = e_q;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (read_go) begin
			rd_a <= mem[{refp_q, rd_e}];
			rd_b <= mem[{candp_c, rd_e}];
		end
	end

	logic signed [16:0] diff;
	logic [33:0] sq;
	assign diff = $signed({rd_a[15], rd_a}) - $signed({rd_b[15], rd_b});
	assign sq = $unsigned(34'(diff) * 34'(diff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= read_go;
		end
	end

	logic [37:0] sub;
	logic [37:0] shl;
	logic [37:0] div_in;
	assign shl = {rem_q[36:0], 1'b0};
	assign div_in = {shl[37:1], sum_q[6'(dcnt_q - 6'd1)]};
	assign sub = div_in - 38'(len);
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r0_q <= 11'({6'b0, grid_row} * {5'b0, sk});
			c0_q <= 11'({6'b0, grid_col} * {5'b0, sk});
			ii_q <= '0;
			jj_q <= '0;
		end
		if (cmd.cand_init || (cmd.start)) begin
			e_q <= '0;
			sum_q <= '0;
		end
		if (!cmd.start && cmd.cand_init && !cmd.adv) begin
			refp_q <= 10'(c0_q * 11'($unsigned(gr)) + r0_q);
		end
		if (cmd.adv) begin
			if (jj_q == sr - 4'd1) begin
				jj_q <= '0;
				ii_q <= ii_q + 4'd1;
			end else begin
				jj_q <= jj_q + 4'd1;
			end
		end
		if (read_go) e_q <= e_q + 6'd1;
		if (rd_vld_q) sum_q <= sum_q + 38'(sq);
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			qsat_q <= 1'b0;
			dcnt_q <= 6'd38;
		end
		if (cmd.div_step) begin
			if (!sub[37]) begin
				rem_q <= sub;
				quo_q <= {quo_q[30:0], 1'b1};
				qsat_q <= qsat_q | quo_q[31];
			end else begin
				rem_q <= div_in;
				quo_q <= {quo_q[30:0], 1'b0};
				qsat_q <= qsat_q | quo_q[31];
			end
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.emit) begin
			res_far <= far_c;
			res_distance <= far_c ? FAR_DISTANCE : (qsat_q ? 32'hFFFF_FFFF : quo_q);
			res_index <= 6'({2'b0, ii_q} * {2'b0, sr} + {2'b0, jj_q});
			res_last <= sts.win_last;
		end
	end
endmodule

// ===== sv/patch_search_window_distance_unit.sv =====
// Patch distance unit for non-local-means search. Load items write one
// signed Q8.8 sample into a 64K-entry store (patch_index*64+element_index);
// they give no result. A compute item first checks the reference patch and
// then walks the search window column offset outer, row offset inner,
// giving one result per candidate. An in-grid candidate reads its
// patch_rows*patch_cols elements serially through the single read stream,
// then runs the bit-serial divider and emits; an out-of-grid candidate
// gives 20.0 without reads or division. A result may wait on a stalled
// receiver. The store needs no clearing.
module patch_search_window_distance_unit import nlm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [5:0]  element_index,
	input  logic [9:0]  patch_index,
	input  logic signed [15:0] sample,
	input  logic [4:0]  grid_col,
	input  logic [4:0]  grid_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] distance,
	output logic [5:0]  search_index,
	output logic        out_of_range,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	logic [5:0] image_rows_q, image_cols_q, skip_step_q;
	logic [3:0] patch_rows_q, patch_cols_q, search_rows_q, search_cols_q;
	nlm_cmd_t cmd;
	nlm_sts_t sts;
	logic busy, in_xfer, out_free;

	assign cfg_ready = 1'b1;
	// Hold the input while a compute request walks the window.
	assign in_stall = busy;
	assign in_xfer = in_valid && !in_stall;
	// A result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= 6'd32;
			image_cols_q <= 6'd32;
			patch_rows_q <= 4'd3;
			patch_cols_q <= 4'd3;
			search_rows_q <= 4'd7;
			search_cols_q <= 4'd7;
			skip_step_q <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_ROWS:  image_rows_q <= cfg_data;
				REG_IMAGE_COLS:  image_cols_q <= cfg_data;
				REG_PATCH_ROWS:  patch_rows_q <= cfg_data[3:0];
				REG_PATCH_COLS:  patch_cols_q <= cfg_data[3:0];
				REG_SEARCH_ROWS: search_rows_q <= cfg_data[3:0];
				REG_SEARCH_COLS: search_cols_q <= cfg_data[3:0];
				REG_SKIP_STEP:   skip_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	nlm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req(in_xfer && command == CMD_COMPUTE),
		.sts(sts), .out_free(out_free), .cmd(cmd), .busy(busy)
	);

	nlm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wr_en(in_xfer && command == CMD_LOAD),
		.wr_addr({patch_index, element_index}),
		.wr_data(sample),
		.grid_col(grid_col), .grid_row(grid_row),
		.image_rows(image_rows_q), .image_cols(image_cols_q),
		.patch_rows(patch_rows_q), .patch_cols(patch_cols_q),
		.search_rows(search_rows_q), .search_cols(search_cols_q),
		.skip_step(skip_step_q),
		.res_distance(distance), .res_index(search_index),
		.res_far(out_of_range), .res_last(last)
	);

	a_no_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free) else $error("result emitted over a waiting result");
	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.emit && !cmd.div_step) else $error("datapath active while idle");
	a_far_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> distance == FAR_DISTANCE)
		else $error("out-of-range candidate with wrong distance");
endmodule
